FILE: sv/assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: sv/owts_pkg.sv
// ---------------------------------------------------------------------------
// owts_pkg
// shared types, codes and crc helpers for the thermometer scratchpad
// ---------------------------------------------------------------------------
package owts_pkg;

  localparam int SCR_DEPTH = 8;
  localparam int SCR_AW    = 3;

  // request codes on the command field
  localparam logic [1:0] CMD_BYTE      = 2'd0;
  localparam logic [1:0] CMD_SET_TEMP  = 2'd1;
  localparam logic [1:0] CMD_BUS_RESET = 2'd2;

  // bus function commands
  localparam logic [7:0] FN_WRITE   = 8'h4E;
  localparam logic [7:0] FN_READ    = 8'hBE;
  localparam logic [7:0] FN_COPY    = 8'h48;
  localparam logic [7:0] FN_RECALL  = 8'hB8;
  localparam logic [7:0] FN_POWER   = 8'hB4;
  localparam logic [7:0] FN_CONVERT = 8'h44;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // temperature format masks
  localparam logic [15:0] NORM_POS_MASK = 16'h07FF;
  localparam logic [15:0] NORM_NEG_FILL = 16'hF800;
  localparam logic [15:0] LEG_POS_MASK  = 16'h00FF;
  localparam logic [15:0] LEG_NEG_FILL  = 16'hFF00;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // scratchpad memory port request
  typedef struct packed {
    logic              we;
    logic [SCR_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [SCR_AW-1:0] raddr;
  } scr_req_t;

  function automatic logic [7:0] scr_reset_byte(input logic [SCR_AW-1:0] addr);
    logic [7:0] b;
    case (addr)
      3'd0:    b = 8'hA0;
      3'd1:    b = 8'h00;
      3'd2:    b = 8'h4B;
      3'd3:    b = 8'h46;
      3'd4:    b = 8'h7F;
      3'd5:    b = 8'hFF;
      3'd6:    b = 8'h00;
      3'd7:    b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one byte of crc-8, lsb first, reflected polynomial
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] v;
    c = crc_in;
    v = data;
    for (int b = 0; b < 8; b++) begin
      if ((c[0] ^ v[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_reset_pad();
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < SCR_DEPTH; i++) begin
      c = crc8_byte(c, scr_reset_byte(SCR_AW'(i)));
    end
    return c;
  endfunction

  localparam logic [7:0] CHECK_RESET = crc8_reset_pad();

endpackage

FILE: sv/owts_scratch_ram.sv
// ---------------------------------------------------------------------------
// owts_scratch_ram
// 8 x 8 scratchpad memory, one write and one registered read port;
// entries never written read back as their power-on value
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module owts_scratch_ram (
  input  logic              clk,
  input  logic              rst,
  input  owts_pkg::scr_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0]                     mem [owts_pkg::SCR_DEPTH];
  logic [owts_pkg::SCR_DEPTH-1:0] written;
  logic [7:0]                     rd_q;
  logic                           rd_dflt;
  logic [owts_pkg::SCR_AW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q    <= mem[req.raddr];
      rd_addr <= req.raddr;
    end
  end

  // written flags and the default select are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_dflt <= 1'b1;
    end else begin
      if (req.re) begin
        rd_dflt <= !written[req.raddr];
      end
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_dflt ? owts_pkg::scr_reset_byte(rd_addr) : rd_q;

  `ASSERT_NEVER(a_no_rw_same_cycle, req.we && req.re, "scratch ram read and write overlap")

endmodule

FILE: sv/onewire_temp_sensor_scratchpad.sv
// ---------------------------------------------------------------------------
// onewire_temp_sensor_scratchpad
// slave-side function layer of a 1-wire thermometer: scratchpad, crc, commands
// ---------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only while the block is
// idle. The 8-byte scratchpad sits in a small synchronous ram with a
// registered read port and the crc-8 check byte in a register. A bus reset,
// a plain command byte and ignored bytes are handled without leaving idle. A
// write-scratchpad data byte is stored and then starts a crc walk that reads
// the eight entries back through the single read port. A set-temperature
// request is converted, writes entries 0 and 1 through the single write port
// and then runs the crc walk. Read scratchpad sends nine results; each
// scratchpad byte costs a ram read plus a load of the output register, and a
// new byte is fetched only once the previous one has left, so the request
// side stays busy through the whole read plus any output stall. An unknown
// command gives one error result and waits for the output register to be
// free. The output register decouples the two sides: a result may wait there
// while the next request is taken.
// legacy_mode is written through cfg_we/cfg_wdata; the user writes it only
// while idle, the block itself does not enforce this.
`include "assert_macros.svh"

module onewire_temp_sensor_scratchpad (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         bus_byte,
  input  logic signed [15:0] temperature_raw,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [7:0]         out_byte,
  output logic               last_byte
);

  typedef enum logic [2:0] {
    IDLE,
    TEMP_LO,
    TEMP_HI,
    CRC_WALK,
    RD_ISSUE,
    RD_LOAD,
    RD_CHECK,
    ERR_OUT
  } state_t;

  // transaction phase
  typedef enum logic [1:0] {
    PH_CMD,
    PH_WRITE,
    PH_IGNORE
  } phase_t;

  state_t                      state;
  phase_t                      phase;
  logic [1:0]                  wpos;
  logic                        legacy_mode;
  logic [7:0]                  check_byte;
  logic [15:0]                 hold_word;   // temperature word or rejected command
  logic [3:0]                  crc_cnt;     // reads issued in the crc walk
  logic                        rd_pend;     // ram data arrives this cycle
  logic [7:0]                  crc_acc;
  logic [owts_pkg::SCR_AW-1:0] rd_idx;

  owts_pkg::scr_req_t          req;
  logic [7:0]                  rdata;

  // temperature conversion
  logic signed [16:0]          q_sum;
  logic signed [16:0]          q_div;
  logic [15:0]                 temp_word;

  owts_scratch_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  assign in_ready = (state == IDLE);

  // legacy: divide by 8 truncating toward zero, bias negatives by 7
  always_comb begin
    q_sum = {temperature_raw[15], temperature_raw}
          + (temperature_raw[15] ? 17'sd7 : 17'sd0);
    q_div = q_sum >>> 3;
    if (legacy_mode) begin
      if (q_div[16]) begin
        temp_word = q_div[15:0] | owts_pkg::LEG_NEG_FILL;
      end else begin
        temp_word = q_div[15:0] & owts_pkg::LEG_POS_MASK;
      end
    end else begin
      if (temperature_raw[15]) begin
        temp_word = temperature_raw | owts_pkg::NORM_NEG_FILL;
      end else begin
        temp_word = temperature_raw & owts_pkg::NORM_POS_MASK;
      end
    end
  end

  // ram port
  always_comb begin
    req = '0;
    case (state)
      IDLE: begin
        if (in_valid && command == owts_pkg::CMD_BYTE && phase == PH_WRITE) begin
          req.we    = 1'b1;
          req.waddr = owts_pkg::SCR_AW'(2) + {1'b0, wpos};
          req.wdata = bus_byte;
        end
      end
      TEMP_LO: begin
        req.we    = 1'b1;
        req.waddr = owts_pkg::SCR_AW'(0);
        req.wdata = hold_word[7:0];
      end
      TEMP_HI: begin
        req.we    = 1'b1;
        req.waddr = owts_pkg::SCR_AW'(1);
        req.wdata = hold_word[15:8];
      end
      CRC_WALK: begin
        req.re    = !crc_cnt[3];
        req.raddr = crc_cnt[2:0];
      end
      RD_ISSUE: begin
        req.re    = !out_valid;
        req.raddr = rd_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      phase       <= PH_CMD;
      wpos        <= 2'd0;
      legacy_mode <= 1'b0;
      check_byte  <= owts_pkg::CHECK_RESET;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        legacy_mode <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= 1'b0;

      case (state)
        IDLE: begin
          if (in_valid) begin
            case (command)
              owts_pkg::CMD_SET_TEMP: begin
                hold_word <= temp_word;
                state     <= TEMP_LO;
              end
              owts_pkg::CMD_BUS_RESET: begin
                phase <= PH_CMD;
                wpos  <= 2'd0;
              end
              owts_pkg::CMD_BYTE: begin
                case (phase)
                  PH_CMD: begin
                    case (bus_byte)
                      owts_pkg::FN_WRITE: begin
                        phase <= PH_WRITE;
                        wpos  <= 2'd0;
                      end
                      owts_pkg::FN_READ: begin
                        phase  <= PH_IGNORE;
                        rd_idx <= '0;
                        state  <= RD_ISSUE;
                      end
                      owts_pkg::FN_COPY, owts_pkg::FN_RECALL,
                      owts_pkg::FN_POWER, owts_pkg::FN_CONVERT: begin
                        phase <= PH_IGNORE;
                      end
                      default: begin
                        // unknown command, report it once
                        phase     <= PH_IGNORE;
                        hold_word <= {8'h00, bus_byte};
                        state     <= ERR_OUT;
                      end
                    endcase
                  end
                  PH_WRITE: begin
                    // data byte stored by the ram port this cycle
                    wpos <= wpos + 2'd1;
                    if (wpos == 2'd2) begin
                      phase <= PH_IGNORE;
                    end
                    crc_cnt <= 4'd0;
                    crc_acc <= 8'h00;
                    state   <= CRC_WALK;
                  end
                  default: begin
                  end
                endcase
              end
              default: begin
              end
            endcase
          end
        end
        TEMP_LO: begin
          state <= TEMP_HI;
        end
        TEMP_HI: begin
          crc_cnt <= 4'd0;
          crc_acc <= 8'h00;
          state   <= CRC_WALK;
        end
        CRC_WALK: begin
          // reads go out back to back, crc folds in one byte per cycle
          if (!crc_cnt[3]) begin
            crc_cnt <= crc_cnt + 4'd1;
            rd_pend <= 1'b1;
          end
          if (rd_pend) begin
            if (crc_cnt[3]) begin
              check_byte <= owts_pkg::crc8_byte(crc_acc, rdata);
              state      <= IDLE;
            end else begin
              crc_acc <= owts_pkg::crc8_byte(crc_acc, rdata);
            end
          end
        end
        RD_ISSUE: begin
          if (!out_valid) begin
            state <= RD_LOAD;
          end
        end
        RD_LOAD: begin
          out_valid   <= 1'b1;
          result_kind <= owts_pkg::KIND_DATA;
          out_byte    <= rdata;
          last_byte   <= 1'b0;
          if (rd_idx == owts_pkg::SCR_AW'(owts_pkg::SCR_DEPTH - 1)) begin
            state <= RD_CHECK;
          end else begin
            rd_idx <= rd_idx + owts_pkg::SCR_AW'(1);
            state  <= RD_ISSUE;
          end
        end
        RD_CHECK: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            result_kind <= owts_pkg::KIND_DATA;
            out_byte    <= check_byte;
            last_byte   <= 1'b1;
            state       <= IDLE;
          end
        end
        ERR_OUT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            result_kind <= owts_pkg::KIND_ERROR;
            out_byte    <= hold_word[7:0];
            last_byte   <= 1'b1;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // a fetched scratchpad byte always finds the output register free
  `ASSERT_CLK(a_load_slot_free, (state == RD_LOAD) |-> !out_valid, "read byte with output busy")
  // an error result is always the final result of its request
  `ASSERT_CLK(a_err_is_last, (out_valid && result_kind) |-> last_byte, "error result not last")
  // the crc walk only finishes with the last byte in flight
  `ASSERT_CLK(a_crc_tail, (state == CRC_WALK && crc_cnt[3]) |-> rd_pend, "crc walk lost a byte")

endmodule

FILE: tb/tb_onewire_temp_sensor_scratchpad.sv
// ---------------------------------------------------------------------------
// tb_onewire_temp_sensor_scratchpad
// self-checking bench for the thermometer scratchpad function layer: a queue
// driven request driver and a result monitor, checked against an in-bench
// scratchpad/crc predictor in both temperature formats
// ---------------------------------------------------------------------------
module tb_onewire_temp_sensor_scratchpad;

  timeunit 1ns;
  timeprecision 1ps;

  // command code with no meaning to the block, must be dropped silently
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // worst run is far below this: 9 results per read, each behind a receiver stall
  localparam int CYCLE_LIMIT = 400000;
  // quiet window after the last result, covers the longest crc walk with margin
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         data;
    logic signed [15:0] temp;
  } bus_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } bus_result_t;

  // transaction phase of the predicted slave
  typedef enum logic [1:0] {
    TXN_AWAIT_CMD,
    TXN_WRITE_DATA,
    TXN_IGNORE
  } txn_phase_t;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // block ports, all driven to known values from time zero
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = owts_pkg::CMD_BUS_RESET;
  logic [7:0]         bus_byte = 8'h00;
  logic signed [15:0] temperature_raw = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               result_kind;
  logic [7:0]         out_byte;
  logic               last_byte;

  // stimulus and expectation stores
  bus_req_t    pending_reqs[$];
  bus_result_t expected_bytes[$];
  bus_req_t    drive_req;
  bus_result_t seen_result;
  bus_result_t want_result;
  bit          req_taken = 1'b0;

  // idling control: gap_pct is shared by both sides, rx_hold_left holds off the receiver
  int gap_pct = 37;
  int rx_hold_left = 0;

  // predicted slave state
  logic [7:0] pad_mem [owts_pkg::SCR_DEPTH];
  logic [7:0] pad_crc;
  txn_phase_t txn_phase;
  int         wr_pos;
  logic       legacy_fmt;

  // bookkeeping
  int cycle_count = 0;
  int mismatches = 0;
  int reqs_accepted = 0;
  int results_checked = 0;
  int reads_predicted = 0;
  int errors_predicted = 0;
  int temps_predicted = 0;

  onewire_temp_sensor_scratchpad dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .bus_byte        (bus_byte),
    .temperature_raw (temperature_raw),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .out_byte        (out_byte),
    .last_byte       (last_byte)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // dallas crc-8 over the whole pad, lsb first, starting from zero
  function automatic logic [7:0] pad_check();
    logic [7:0] c;
    logic [7:0] v;
    logic       fb;
    int         i;
    int         b;
    c = 8'h00;
    for (i = 0; i < owts_pkg::SCR_DEPTH; i++) begin
      v = pad_mem[i];
      for (b = 0; b < 8; b++) begin
        fb = c[0] ^ v[0];
        c = c >> 1;
        if (fb) begin
          c = c ^ owts_pkg::CRC_POLY;
        end
        v = v >> 1;
      end
    end
    return c;
  endfunction

  // raw sixteenths to the temperature register word, wrapping, never saturating
  function automatic logic [15:0] temp_word(input logic signed [15:0] raw,
                                            input logic legacy);
    int         v;
    logic [15:0] w;
    v = raw;
    if (legacy) begin
      // integer division truncates toward zero, as the legacy format wants
      v = v / 8;
    end
    if (v >= 0) begin
      w = 16'(v) & (legacy ? owts_pkg::LEG_POS_MASK : owts_pkg::NORM_POS_MASK);
    end else begin
      w = 16'(v) | (legacy ? owts_pkg::LEG_NEG_FILL : owts_pkg::NORM_NEG_FILL);
    end
    return w;
  endfunction

  task automatic pad_power_up();
    pad_mem[0] = 8'hA0;
    pad_mem[1] = 8'h00;
    pad_mem[2] = 8'h4B;
    pad_mem[3] = 8'h46;
    pad_mem[4] = 8'h7F;
    pad_mem[5] = 8'hFF;
    pad_mem[6] = 8'h00;
    pad_mem[7] = 8'h10;
    pad_crc = pad_check();
    txn_phase = TXN_AWAIT_CMD;
    wr_pos = 0;
    legacy_fmt = 1'b0;
  endtask

  // one accepted request: update the pad and queue whatever goes out on the bus
  task automatic scratchpad_predict(input bus_req_t r);
    logic [15:0] w;
    int          k;
    case (r.cmd)
      owts_pkg::CMD_SET_TEMP: begin
        w = temp_word(r.temp, legacy_fmt);
        pad_mem[0] = w[7:0];
        pad_mem[1] = w[15:8];
        pad_crc = pad_check();
        temps_predicted++;
      end
      owts_pkg::CMD_BUS_RESET: begin
        txn_phase = TXN_AWAIT_CMD;
        wr_pos = 0;
      end
      owts_pkg::CMD_BYTE: begin
        if (txn_phase == TXN_AWAIT_CMD) begin
          case (r.data)
            owts_pkg::FN_WRITE: begin
              txn_phase = TXN_WRITE_DATA;
              wr_pos = 0;
            end
            owts_pkg::FN_READ: begin
              txn_phase = TXN_IGNORE;
              for (k = 0; k < owts_pkg::SCR_DEPTH; k++) begin
                expected_bytes.push_back('{kind: owts_pkg::KIND_DATA, data: pad_mem[k],
                                           last: 1'b0});
              end
              expected_bytes.push_back('{kind: owts_pkg::KIND_DATA, data: pad_crc,
                                         last: 1'b1});
              reads_predicted++;
            end
            owts_pkg::FN_COPY, owts_pkg::FN_RECALL,
            owts_pkg::FN_POWER, owts_pkg::FN_CONVERT: begin
              txn_phase = TXN_IGNORE;
            end
            default: begin
              txn_phase = TXN_IGNORE;
              expected_bytes.push_back('{kind: owts_pkg::KIND_ERROR, data: r.data,
                                         last: 1'b1});
              errors_predicted++;
            end
          endcase
        end else if (txn_phase == TXN_WRITE_DATA) begin
          // data lands in entries 2..4, crc refreshed after every byte
          pad_mem[2 + wr_pos] = r.data;
          pad_crc = pad_check();
          wr_pos++;
          if (wr_pos >= 3) begin
            txn_phase = TXN_IGNORE;
          end
        end
        // anything else: bytes after a handled command are dropped
      end
      default: begin
        // unused command code, no effect at all
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request driver: presents at the falling edge, records acceptance at the rising
  // ---------------------------------------------------------------------------

  function automatic bit take_break(input int pct);
    return (pct > 0) && ($urandom_range(99) < pct);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      // ports are stable here, they only move at the falling edge
      scratchpad_predict('{cmd: command, data: bus_byte, temp: temperature_raw});
      reqs_accepted++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && !take_break(gap_pct)) begin
        drive_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        command <= drive_req.cmd;
        bus_byte <= drive_req.data;
        temperature_raw <= drive_req.temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // otherwise the current request is held unchanged until it is taken
  end

  // ---------------------------------------------------------------------------
  // result side: back-pressure at the falling edge, checking at the rising
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      // long hold-off so the block backs up and stalls its request side
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break(gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result = '{kind: result_kind, data: out_byte, last: last_byte};
      results_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: kind %0d byte %02h last %0d",
                   $realtime, seen_result.kind, seen_result.data, seen_result.last);
        end
      end else begin
        want_result = expected_bytes.pop_front();
        if (seen_result != want_result) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result mismatch: expected kind %0d byte %02h last %0d,",
                     $realtime, want_result.kind, want_result.data, want_result.last,
                     " got kind %0d byte %02h last %0d",
                     seen_result.kind, seen_result.data, seen_result.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_onewire_temp_sensor_scratchpad failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic [1:0] c, input logic [7:0] b,
                           input logic signed [15:0] t);
    pending_reqs.push_back('{cmd: c, data: b, temp: t});
  endtask

  // unused fields carry random values so every bit toggles
  task automatic queue_byte(input logic [7:0] b);
    queue_req(owts_pkg::CMD_BYTE, b, 16'($urandom));
  endtask

  task automatic queue_bus_reset();
    queue_req(owts_pkg::CMD_BUS_RESET, 8'($urandom), 16'($urandom));
  endtask

  task automatic queue_temp(input logic signed [15:0] t);
    queue_req(owts_pkg::CMD_SET_TEMP, 8'($urandom), t);
  endtask

  // wait until nothing is queued, in flight or owed, then let the block go quiet
  task automatic wait_quiet();
    @(posedge clk);
    #1;
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input logic legacy);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= legacy;
    legacy_fmt = legacy;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed transactions with random content, some noise mixed in
  task automatic random_traffic(input int target);
    int         made;
    int         pick;
    int         n;
    logic [7:0] b;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        case ($urandom_range(7))
          0:       queue_temp(16'sh8000);
          1:       queue_temp(16'sh7FFF);
          2:       queue_temp(16'($urandom_range(31)) - 16'sd16);
          default: queue_temp(16'($urandom));
        endcase
        made++;
      end else begin
        // now and then skip the bus reset so the command byte is dropped
        if ($urandom_range(9) != 0) begin
          queue_bus_reset();
          made++;
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
          queue_byte(owts_pkg::FN_READ);
        end else if (pick < 60) begin
          // zero to four data bytes: incomplete, full and overlong writes
          queue_byte(owts_pkg::FN_WRITE);
          n = $urandom_range(4);
          repeat (n) begin
            queue_byte(8'($urandom));
            made++;
          end
        end else if (pick < 72) begin
          case ($urandom_range(3))
            0:       b = owts_pkg::FN_COPY;
            1:       b = owts_pkg::FN_RECALL;
            2:       b = owts_pkg::FN_POWER;
            default: b = owts_pkg::FN_CONVERT;
          endcase
          queue_byte(b);
        end else if (pick < 88) begin
          do begin
            b = 8'($urandom);
          end while (b == owts_pkg::FN_WRITE || b == owts_pkg::FN_READ ||
                     b == owts_pkg::FN_COPY || b == owts_pkg::FN_RECALL ||
                     b == owts_pkg::FN_POWER || b == owts_pkg::FN_CONVERT);
          queue_byte(b);
        end else begin
          queue_byte(8'($urandom));
        end
        made++;
        // trailing bytes that should be ignored until the next bus reset
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(2, 1)) queue_byte(8'($urandom));
        end
        if ($urandom_range(15) == 0) begin
          queue_req(CMD_UNUSED, 8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    pad_power_up();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, normal format: power-up pad, every function command, the
    // overlong write, unused code, bytes after a command
    queue_byte(owts_pkg::FN_READ);
    queue_byte(8'h00);
    queue_req(CMD_UNUSED, 8'hFF, 16'shFFFF);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_WRITE);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_byte(8'h11);
    queue_temp(16'sh7FFF);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    queue_temp(16'sh8000);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_COPY);
    queue_byte(owts_pkg::FN_READ);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_RECALL);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_POWER);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_CONVERT);
    queue_bus_reset();
    queue_byte(8'h00);
    queue_bus_reset();
    queue_byte(8'hFF);
    wait_quiet();

    // directed, legacy format: truncation toward zero and both sign fills,
    // plus an incomplete write left with a current crc
    write_format(1'b1);
    queue_temp(16'sh7FFF);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    queue_temp(16'sh8000);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    queue_temp(-16'sd7);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    queue_temp(-16'sd9);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_WRITE);
    queue_byte(8'hC3);
    queue_bus_reset();
    queue_byte(owts_pkg::FN_READ);
    wait_quiet();

    // random, no idling on either side
    write_format(1'b0);
    gap_pct = 0;
    random_traffic(30);
    wait_quiet();

    // random, legacy, with a long receiver hold-off over a burst of reads
    write_format(1'b1);
    gap_pct = 37;
    @(posedge clk);
    rx_hold_left = 400;
    repeat (10) begin
      queue_bus_reset();
      queue_byte(owts_pkg::FN_READ);
    end
    random_traffic(30);
    wait_quiet();

    write_format(1'b0);
    random_traffic(30);
    wait_quiet();

    write_format(1'b1);
    random_traffic(30);
    wait_quiet();

    $display("summary: %0d requests, %0d results checked; %0d reads, %0d command errors,",
             reqs_accepted, results_checked, reads_predicted, errors_predicted);
    $display("summary: %0d temperature loads across normal and legacy formats, %0d mismatches",
             temps_predicted, mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb_onewire_temp_sensor_scratchpad passed");
    end else begin
      $display("tb_onewire_temp_sensor_scratchpad failed");
    end
    $finish;
  end

endmodule
